@@ src/rtt_pkg.sv @@
package rtt_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;

  typedef enum logic [2:0] {
    OP_STORE  = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FIND   = 3'd2,
    OP_RESEND = 3'd3,
    OP_CHECK  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_STORED    = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_REMOVED   = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FOUND     = 3'd4,
    KIND_RESEND    = 3'd5,
    KIND_TIMED_OUT = 3'd6,
    KIND_SCAN_DONE = 3'd7
  } kind_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] pkt_id;
    logic [11:0] length;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] pkt_id_res;
    logic [3:0]  slot;
    logic [11:0] length_res;
    logic [7:0]  rtx_count;
    logic        last;
  } out_t;

  // one table entry as held in the RAM
  typedef struct packed {
    logic [31:0] id;
    logic [11:0] length;
    logic [31:0] sent_ms;
    logic [7:0]  retries;
  } entry_t;

  typedef struct packed {
    logic  load;       // capture the incoming item
    logic  idx_rst;    // slot walk back to slot 0
    logic  idx_inc;    // slot walk to next slot
    logic  push;       // load a result into the output register
    kind_e push_kind;
    logic  wr_store;   // write new entry at lowest free slot
    logic  wr_resend;  // restamp current slot, bump retries
    logic  clr_valid;  // free current slot
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_remove;   // held item is a remove (else find)
    logic op_resend;   // held item is a resend scan (else check)
    logic hit;         // current slot valid and id matches
    logic expired;     // current slot valid and older than timeout
    logic at_last;     // slot walk sits on the last slot
    logic has_free;    // some slot is free
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage

@@ src/retransmit_timeout_table.sv @@
// Table of sent packets awaiting acknowledgement, ENTRIES slots deep.
// Input channel (in_valid_i / in_stall_o / in_item_i) takes one item at a
// time: store, remove, find, resend scan or check scan, with the current
// millisecond time. Output channel (out_valid_o / out_stall_i / out_item_o)
// returns result items; last marks the final result of an item.
// Store gives a stored or full result; remove/find walk the slots one per
// cycle until a hit or the last slot; a scan walks all slots and emits its
// timed-out entries and a scan-done item. The slot walk over the entry RAM
// (one read port, one slot per cycle unless a stalled result holds it) sets
// the rate; the next item is taken the cycle after the current one's final
// result is registered. Codes 5 to 7 are taken and dropped without results.
// A finished result sits in an output register, so a new item is taken while
// it waits. When the receiver stalls, the walk holds on the slot that has a
// result to give and resumes once the output register frees.
// Reset clears all slot valid bits and the output register and loads the
// timeout register with 1000 ms; entry contents need no clearing pass.
// cfg_we_i / cfg_wdata_i write timeout_ms; write only while idle.
module retransmit_timeout_table #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned MAX_LENGTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rtt_pkg::in_t                 in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rtt_pkg::out_t                out_item_o,
  input  logic                         cfg_we_i,
  input  logic [rtt_pkg::TimeoutW-1:0] cfg_wdata_i
);
  import rtt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: decodes the item and steps through slots
  rtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_item_i.operation),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry RAM, valid bits, timeout register, compare logic, output register
  rtt_dp #(
    .ENTRIES    (ENTRIES),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // a result is only loaded when the output register can take it
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.out_free)
    else $error("result pushed into occupied output register");

  // at most one table update per cycle
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.wr_store, cmd.wr_resend, cmd.clr_valid}))
    else $error("conflicting table updates");

  // an accepted item never produces a result in its accept cycle
  a_accept_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !cmd.push)
    else $error("result pushed while accepting an item");
`endif

endmodule

@@ src/rtt_ram.sv @@
module rtt_ram #(
  parameter int unsigned WIDTH = 84,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rtt_ctrl.sv @@
module rtt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [2:0]         in_op_i,
  output logic               in_stall_o,
  input  rtt_pkg::ctrl_sts_t sts_i,
  output rtt_pkg::ctrl_cmd_t cmd_o
);
  import rtt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SEARCH,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.push_kind = KIND_SCAN_DONE;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.idx_rst = 1'b1;
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (op_e'(in_op_i))
            OP_STORE:            state_d = ST_STORE;
            OP_REMOVE, OP_FIND:  state_d = ST_SEARCH;
            OP_RESEND, OP_CHECK: state_d = ST_SCAN;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_STORE: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = sts_i.has_free ? KIND_STORED : KIND_FULL;
          cmd_o.wr_store  = sts_i.has_free;
          state_d         = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (sts_i.hit) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = sts_i.op_remove ? KIND_REMOVED : KIND_FOUND;
            cmd_o.clr_valid = sts_i.op_remove;
            state_d         = ST_IDLE;
          end
        end else if (sts_i.at_last) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = KIND_NOT_FOUND;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!sts_i.expired || sts_i.out_free) begin
          if (sts_i.expired) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = sts_i.op_resend ? KIND_RESEND : KIND_TIMED_OUT;
            cmd_o.wr_resend = sts_i.op_resend;
          end
          if (sts_i.at_last) begin
            cmd_o.idx_rst = 1'b1;
            state_d       = ST_DONE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_SCAN_DONE;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/rtt_dp.sv @@
module rtt_dp #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned MAX_LENGTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtt_pkg::in_t                  in_item_i,
  input  logic                          cfg_we_i,
  input  logic [rtt_pkg::TimeoutW-1:0]  cfg_wdata_i,
  input  rtt_pkg::ctrl_cmd_t            cmd_i,
  output rtt_pkg::ctrl_sts_t            sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rtt_pkg::out_t                 out_item_o
);
  import rtt_pkg::*;

  localparam int unsigned IdxW   = $clog2(ENTRIES);
  localparam int unsigned EntryW = $bits(entry_t);

  in_t                 item_q;
  logic [TimeoutW-1:0] timeout_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q;

  entry_t          rd_entry;
  entry_t          wr_entry;
  logic [EntryW-1:0] rdata;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] free_idx;
  logic            has_free;
  logic [11:0]     len_clamped;
  logic [31:0]     age;
  logic [7:0]      retries_inc;
  logic            cur_valid;
  logic            out_free;

  // lowest free slot
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_rst) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  assign rd_entry  = entry_t'(rdata);
  assign cur_valid = valid_q[idx_q];
  assign age       = item_q.now_ms - rd_entry.sent_ms;
  assign retries_inc = (rd_entry.retries == 8'hFF) ? 8'hFF : rd_entry.retries + 8'd1;
  assign len_clamped = ({4'd0, item_q.length} > 16'(MAX_LENGTH)) ?
                       12'(MAX_LENGTH) : item_q.length;

  always_comb begin
    wr_en   = cmd_i.wr_store || cmd_i.wr_resend;
    wr_addr = cmd_i.wr_store ? free_idx : idx_q;
    if (cmd_i.wr_store) begin
      wr_entry.id      = item_q.pkt_id;
      wr_entry.length  = len_clamped;
      wr_entry.sent_ms = item_q.now_ms;
      wr_entry.retries = 8'd0;
    end else begin
      wr_entry.id      = rd_entry.id;
      wr_entry.length  = rd_entry.length;
      wr_entry.sent_ms = item_q.now_ms;
      wr_entry.retries = retries_inc;
    end
  end

  rtt_ram #(
    .WIDTH (EntryW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (EntryW'(wr_entry)),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.wr_store) begin
      valid_d[free_idx] = 1'b1;
    end
    if (cmd_i.clr_valid) begin
      valid_d[idx_q] = 1'b0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.op_remove = (op_e'(item_q.operation) == OP_REMOVE);
    sts_o.op_resend = (op_e'(item_q.operation) == OP_RESEND);
    sts_o.hit       = cur_valid && (rd_entry.id == item_q.pkt_id);
    sts_o.expired   = cur_valid && (age > {16'd0, timeout_q});
    sts_o.at_last   = (idx_q == IdxW'(ENTRIES - 1));
    sts_o.has_free  = has_free;
    sts_o.out_free  = out_free;
  end

  // result formatting
  out_t res;
  always_comb begin
    res      = '0;
    res.kind = cmd_i.push_kind;
    res.last = 1'b1;
    case (cmd_i.push_kind)
      KIND_STORED: begin
        res.pkt_id_res = item_q.pkt_id;
        res.slot       = 4'(free_idx);
        res.length_res = len_clamped;
      end
      KIND_FULL, KIND_NOT_FOUND: begin
        res.pkt_id_res = item_q.pkt_id;
      end
      KIND_REMOVED, KIND_FOUND, KIND_RESEND, KIND_TIMED_OUT: begin
        res.pkt_id_res = rd_entry.id;
        res.slot       = 4'(idx_q);
        res.length_res = rd_entry.length;
        res.rtx_count  = (cmd_i.push_kind == KIND_RESEND) ? retries_inc
                                                          : rd_entry.retries;
        res.last       = (cmd_i.push_kind == KIND_REMOVED) ||
                         (cmd_i.push_kind == KIND_FOUND);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      idx_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.push) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
